/* hw/rtl/hdc_pkg.sv */
// Package holding the types and constants shared by the homopolymer and dimer compressor.
`timescale 1ns / 1ps
`default_nettype none
package hdc_pkg;

    // Configuration register indexes.
    localparam logic REG_COMPRESS_ENABLE = 1'b0;
    localparam logic REG_MAX_REPEAT_LEN  = 1'b1;

    localparam logic [31:0] RUN_LEN_RESET    = 32'd2;
    localparam logic [31:0] RUN_LEN_MAX      = 32'hFFFF_FFFF;
    localparam logic [31:0] MIN_LIMIT        = 32'd4;
    localparam logic [31:0] MAX_REPEAT_RESET = 32'd1000000000;
    localparam logic [1:0]  OUT_SEEN_FULL    = 2'd2;

    typedef struct packed {
        logic [7:0]  last_input;
        logic        have_input;
        logic [7:0]  out_back_one;
        logic [7:0]  out_back_two;
        logic [1:0]  out_seen;
        logic [31:0] run_length;
        logic        surplus_odd;
        logic [7:0]  held_symbol;
    } hdc_state_t;

    localparam hdc_state_t STATE_RESET = '{
        last_input:   8'd0,
        have_input:   1'b0,
        out_back_one: 8'd0,
        out_back_two: 8'd0,
        out_seen:     2'd0,
        run_length:   RUN_LEN_RESET,
        surplus_odd:  1'b0,
        held_symbol:  8'd0
    };

    typedef struct packed {
        logic [7:0] out_symbol;
        logic       symbol_valid;
        logic       sequence_done;
    } hdc_result_t;

    typedef struct packed {
        logic [1:0]  count;
        hdc_result_t first;
        hdc_result_t second;
        hdc_state_t  state;
    } hdc_step_t;

endpackage
`default_nettype wire

/* hw/rtl/hdc_step.sv */
// Combinational update for one symbol: the results it causes and the next state.
`timescale 1ns / 1ps
`default_nettype none
module hdc_step
(
    input  wire logic [7:0]         symbol,
    input  wire logic               end_of_sequence,
    input  wire logic               compress_enable,
    input  wire logic [31:0]        max_repeat_len,
    input  var  hdc_pkg::hdc_state_t state,
    output var  hdc_pkg::hdc_step_t  step
);
    import hdc_pkg::*;

    logic [31:0] limit;
    logic [31:0] run_inc;
    hdc_state_t  st;
    hdc_result_t res [2];
    logic [1:0]  n;

    assign limit   = (max_repeat_len < MIN_LIMIT) ? MIN_LIMIT : max_repeat_len;
    assign run_inc = (state.run_length == RUN_LEN_MAX) ? state.run_length
                                                       : state.run_length + 32'd1;

    always_comb
    begin
        st     = state;
        n      = 2'd0;
        res[0] = '0;
        res[1] = '0;

        if (!compress_enable)
        begin
            res[0] = '{out_symbol: symbol, symbol_valid: 1'b1, sequence_done: end_of_sequence};
            n      = 2'd1;
            st     = STATE_RESET;
        end
        else
        begin
            if (!(state.have_input && symbol == state.last_input))
            begin
                if (state.out_seen < OUT_SEEN_FULL)
                begin
                    res[0]      = '{out_symbol: symbol, symbol_valid: 1'b1, sequence_done: 1'b0};
                    n           = 2'd1;
                    st.out_seen = state.out_seen + 2'd1;
                end
                else if (symbol == state.out_back_two)
                begin
                    st.run_length = run_inc;
                    if (run_inc > limit)
                    begin
                        st.surplus_odd = ~state.surplus_odd;
                        if (!state.surplus_odd)
                        begin
                            st.held_symbol = symbol;
                        end
                    end
                    else
                    begin
                        res[0] = '{out_symbol: symbol, symbol_valid: 1'b1, sequence_done: 1'b0};
                        n      = 2'd1;
                    end
                end
                else
                begin
                    // The alternating run has ended: release a withheld odd surplus first.
                    if (state.surplus_odd)
                    begin
                        res[0] = '{out_symbol: state.held_symbol, symbol_valid: 1'b1,
                                   sequence_done: 1'b0};
                        res[1] = '{out_symbol: symbol, symbol_valid: 1'b1, sequence_done: 1'b0};
                        n      = 2'd2;
                    end
                    else
                    begin
                        res[0] = '{out_symbol: symbol, symbol_valid: 1'b1, sequence_done: 1'b0};
                        n      = 2'd1;
                    end
                    st.run_length  = RUN_LEN_RESET;
                    st.surplus_odd = 1'b0;
                end
                st.out_back_two = state.out_back_one;
                st.out_back_one = symbol;
            end
            st.last_input = symbol;
            st.have_input = 1'b1;

            if (end_of_sequence)
            begin
                if (st.surplus_odd)
                begin
                    res[n[0]] = '{out_symbol: st.held_symbol, symbol_valid: 1'b1,
                                  sequence_done: 1'b0};
                    n = n + 2'd1;
                end
                if (n == 2'd0)
                begin
                    res[0] = '{out_symbol: 8'd0, symbol_valid: 1'b0, sequence_done: 1'b0};
                    n      = 2'd1;
                end
                if (n == 2'd2)
                begin
                    res[1].sequence_done = 1'b1;
                end
                else
                begin
                    res[0].sequence_done = 1'b1;
                end
                st = STATE_RESET;
            end
        end

        step.count  = n;
        step.first  = res[0];
        step.second = res[1];
        step.state  = st;
    end

endmodule
`default_nettype wire

/* hw/rtl/homopolymer_dimer_compressor_top.sv */
// Top level of the homopolymer and alternating-dimer compressor.
//
//  Channel | Signals                                   | Direction | Meaning
//  --------+-------------------------------------------+-----------+-----------------------------
//  s_      | tvalid tready tdata[7:0] tlast            | in        | one symbol per request
//  m_      | tvalid tready tdata[7:0] tuser tlast      | out       | one kept symbol or end marker
//  cfg_    | valid ready index data[31:0]              | in        | register write request
//
// Each accepted symbol is processed in the cycle it is accepted: the step logic updates the run
// state and writes one or two results into a four-entry result queue, so a new symbol can be
// taken every cycle. The output drains one result per cycle while m_tready is high, so a
// symbol causing two results takes two transfers; the input is held off only while fewer than
// two queue entries are free. Reset (asynchronous, active low) clears the run state and the queue
// and returns the registers to their reset values. The configuration port is always ready.
`timescale 1ns / 1ps
`default_nettype none
module homopolymer_dimer_compressor_top
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input symbol stream.
    input  wire logic        s_tvalid,
    output wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] symbol
    input  wire logic        s_tlast,   // end_of_sequence
    // Result stream.
    output wire logic        m_tvalid,
    input  wire logic        m_tready,
    output wire logic [7:0]  m_tdata,   // [7:0] out_symbol
    output wire logic        m_tuser,   // symbol_valid
    output wire logic        m_tlast,   // sequence_done
    // Configuration write channel.
    input  wire logic        cfg_valid,
    output wire logic        cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_data
);
    import hdc_pkg::*;

    localparam int unsigned QUEUE_DEPTH = 4;

    logic        compress_enable_reg;
    logic [31:0] max_repeat_len_reg;

    hdc_state_t  state_reg;
    hdc_step_t   step;

    hdc_result_t queue_reg [QUEUE_DEPTH];
    logic [1:0]  wr_ptr_reg;
    logic [1:0]  wr_ptr_next;
    logic [1:0]  rd_ptr_reg;
    logic [1:0]  rd_ptr_next;
    logic [2:0]  count_reg;
    logic [2:0]  count_next;

    logic        accept;
    logic        pop;
    logic        cfg_write;
    hdc_result_t head;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // Room for the worst case of two results per symbol.
    assign s_tready = (count_reg <= 3'd2);
    assign accept   = s_tvalid && s_tready;

    assign head     = queue_reg[rd_ptr_reg];
    assign m_tvalid = (count_reg != 3'd0);
    assign m_tdata  = head.out_symbol;
    assign m_tuser  = head.symbol_valid;
    assign m_tlast  = head.sequence_done;
    assign pop      = m_tvalid && m_tready;

    hdc_step u_step
    (
        .symbol          (s_tdata),
        .end_of_sequence (s_tlast),
        .compress_enable (compress_enable_reg),
        .max_repeat_len  (max_repeat_len_reg),
        .state           (state_reg),
        .step            (step)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            compress_enable_reg <= 1'b0;
            max_repeat_len_reg  <= MAX_REPEAT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_COMPRESS_ENABLE: compress_enable_reg <= cfg_data[0];
                REG_MAX_REPEAT_LEN:  max_repeat_len_reg  <= cfg_data;
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RESET;
        end
        else if (accept)
        begin
            state_reg <= step.state;
        end
    end

    // Queue pointers and fill count.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (accept)
        begin
            wr_ptr_next = wr_ptr_reg + step.count;
            count_next  = count_next + {1'b0, step.count};
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 2'd1;
            count_next  = count_next - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Result storage: the first result always lands at the write pointer, the second
    // in the entry after it.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            queue_reg[wr_ptr_reg] <= step.first;
            if (step.count == 2'd2)
            begin
                queue_reg[wr_ptr_reg + 2'd1] <= step.second;
            end
        end
    end

`ifndef SYNTH
    // The queue never overfills.
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= 3'd4)
        else $error("result queue overflow");

    // With no symbol seen yet, no kept symbols and no surplus can be recorded.
    assert property (@(posedge clk) disable iff (!rst_n)
        !state_reg.have_input |-> (state_reg.out_seen == 2'd0 && !state_reg.surplus_odd))
        else $error("run state set without a previous symbol");

    // A surplus is only counted once two kept symbols form a run.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.surplus_odd |-> (state_reg.out_seen == OUT_SEEN_FULL))
        else $error("surplus recorded before a run was formed");

    // The run length never drops below its starting value.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.run_length >= RUN_LEN_RESET)
        else $error("run length below its floor");

    // A finished sequence always leaves the run state cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tlast) |=> (!state_reg.have_input && !state_reg.surplus_odd))
        else $error("state not cleared after end of sequence");
`endif

endmodule
`default_nettype wire

/* dv/testbench.sv */
// Self-checking testbench for the homopolymer and dimer compressor top level.
`timescale 1ns / 1ps
module testbench;
    import hdc_pkg::*;

    // Random idling is drawn per request, up to GAP_MAX. The pause after
    // the last awaited result covers a symbol that is still being taken in but
    // produces nothing, such as a dropped repeat or a withheld surplus symbol.
    localparam int unsigned GAP_MAX         = 15;
    localparam int unsigned DRAIN_CYCLES    = 8;
    localparam int unsigned CYCLE_LIMIT     = 200000;
    localparam int unsigned PHASE_ITEMS     = 50;
    localparam int unsigned PHASE_COUNT     = 7;
    localparam int unsigned PAIR_SPAN       = 14;

    // Own copies of the block's constants, kept apart from the design.
    localparam logic [31:0] RUN_START       = 32'd2;
    localparam logic [31:0] RUN_CEILING     = 32'hFFFF_FFFF;
    localparam logic [31:0] LIMIT_FLOOR     = 32'd4;
    localparam logic [31:0] MAX_LEN_DEFAULT = 32'd1000000000;
    localparam logic [1:0]  KEPT_FULL       = 2'd2;

    // Nucleotide letters, used for most symbols so that repeats are frequent.
    localparam logic [7:0]  BASE_A = 8'h41;
    localparam logic [7:0]  BASE_C = 8'h43;
    localparam logic [7:0]  BASE_G = 8'h47;
    localparam logic [7:0]  BASE_T = 8'h54;

    typedef struct packed {
        logic [7:0] sym;
        logic       eos;
    } symbol_req_t;

    // Every input of the block starts at a known value.
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'd0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [31:0] cfg_data  = 32'd0;

    symbol_req_t symbol_q[$];      // symbols waiting to be offered to the block
    hdc_result_t awaited_q[$];     // kept symbols and end markers still to arrive
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;

    homopolymer_dimer_compressor_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // ------------------------------------------------------------------
    // Compression predictor: a mirror of the registers and the run state.
    // ------------------------------------------------------------------
    logic        enable_m    = 1'b0;
    logic [31:0] max_len_m   = MAX_LEN_DEFAULT;
    logic [7:0]  prev_sym    = 8'd0;   // previous raw symbol
    logic        prev_seen   = 1'b0;
    logic [7:0]  kept_one    = 8'd0;   // last two symbols of the kept run
    logic [7:0]  kept_two    = 8'd0;
    logic [1:0]  kept_count  = 2'd0;   // kept symbols so far, stops at two
    logic [31:0] alt_run     = RUN_START;
    logic        odd_surplus = 1'b0;
    logic [7:0]  withheld    = 8'd0;

    function automatic void clear_run_state();
        prev_sym    = 8'd0;
        prev_seen   = 1'b0;
        kept_one    = 8'd0;
        kept_two    = 8'd0;
        kept_count  = 2'd0;
        alt_run     = RUN_START;
        odd_surplus = 1'b0;
        withheld    = 8'd0;
    endfunction

    // Works out the results of one accepted symbol and appends them to awaited_q.
    task automatic compress_step(input logic [7:0] sym, input logic eos);
        hdc_result_t step_out[$];
        logic [31:0] limit;
        limit = (max_len_m < LIMIT_FLOOR) ? LIMIT_FLOOR : max_len_m;
        if (!enable_m)
        begin
            // Pass-through also wipes the run state, so re-enabling starts afresh.
            step_out.push_back('{sym, 1'b1, eos});
            clear_run_state();
        end
        else
        begin
            if (!(prev_seen && sym == prev_sym))
            begin
                if (kept_count < KEPT_FULL)
                begin
                    step_out.push_back('{sym, 1'b1, 1'b0});
                    kept_count = kept_count + 2'd1;
                end
                else if (sym == kept_two)
                begin
                    // The alternating run grows; beyond the limit only parity is kept.
                    if (alt_run != RUN_CEILING)
                        alt_run = alt_run + 32'd1;
                    if (alt_run > limit)
                    begin
                        odd_surplus = ~odd_surplus;
                        if (odd_surplus)
                            withheld = sym;
                    end
                    else
                        step_out.push_back('{sym, 1'b1, 1'b0});
                end
                else
                begin
                    // The run is broken: an odd surplus releases its held symbol first.
                    if (odd_surplus)
                        step_out.push_back('{withheld, 1'b1, 1'b0});
                    step_out.push_back('{sym, 1'b1, 1'b0});
                    alt_run     = RUN_START;
                    odd_surplus = 1'b0;
                end
                kept_two = kept_one;
                kept_one = sym;
            end
            prev_sym  = sym;
            prev_seen = 1'b1;
            if (eos)
            begin
                if (odd_surplus)
                    step_out.push_back('{withheld, 1'b1, 1'b0});
                if (step_out.size() == 0)
                    step_out.push_back('{8'd0, 1'b0, 1'b0});
                step_out[step_out.size() - 1].sequence_done = 1'b1;
                clear_run_state();
            end
        end
        foreach (step_out[k])
            awaited_q.push_back(step_out[k]);
    endtask

    // ------------------------------------------------------------------
    // Symbol driver. Each request is followed by a random gap, except for a
    // stretch of back-to-back requests every 80 symbols. A request is handed
    // to the predictor at the edge where it is accepted.
    // ------------------------------------------------------------------
    int unsigned gap_left   = 0;
    int unsigned items_sent = 0;

    always @(posedge clk)
    begin
        symbol_req_t next_req;
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            if (s_tvalid && s_tready)
                compress_step(s_tdata, s_tlast);
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left = gap_left - 1;
                    s_tvalid <= 1'b0;
                end
                else if (symbol_q.size() > 0)
                begin
                    next_req = symbol_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_req.sym;
                    s_tlast  <= next_req.eos;
                    items_sent = items_sent + 1;
                    gap_left = (items_sent % 80 < 20) ? 0 : $urandom_range(0, GAP_MAX);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor. Every accepted result is checked against the oldest
    // awaited one, then the receiver stalls for a random number of cycles,
    // with a stretch of no stalls every 64 results.
    // ------------------------------------------------------------------
    int unsigned stall_left   = 0;
    int unsigned results_seen = 0;

    always @(posedge clk)
    begin
        hdc_result_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen = results_seen + 1;
                if (awaited_q.size() == 0)
                begin
                    $error("unexpected result: out_symbol %0h symbol_valid %0b sequence_done %0b",
                           m_tdata, m_tuser, m_tlast);
                    error_count = error_count + 1;
                end
                else
                begin
                    want = awaited_q.pop_front();
                    if (m_tdata !== want.out_symbol)
                    begin
                        $error("out_symbol: expected %0h, got %0h", want.out_symbol, m_tdata);
                        error_count = error_count + 1;
                    end
                    if (m_tuser !== want.symbol_valid)
                    begin
                        $error("symbol_valid: expected %0b, got %0b", want.symbol_valid, m_tuser);
                        error_count = error_count + 1;
                    end
                    if (m_tlast !== want.sequence_done)
                    begin
                        $error("sequence_done: expected %0b, got %0b",
                               want.sequence_done, m_tlast);
                        error_count = error_count + 1;
                    end
                end
                stall_left = (results_seen % 64 < 16) ? 0 : $urandom_range(0, GAP_MAX);
            end
            if (stall_left > 0)
            begin
                stall_left = stall_left - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    function automatic void push_symbol(input logic [7:0] sym, input logic eos);
        symbol_q.push_back('{sym, eos});
    endfunction

    // Mostly nucleotide letters, now and then any byte so every bit toggles.
    function automatic logic [7:0] pick_symbol();
        logic [7:0] pick;
        case ($urandom_range(0, 4))
            0:       pick = BASE_A;
            1:       pick = BASE_C;
            2:       pick = BASE_G;
            3:       pick = BASE_T;
            default: pick = 8'($urandom_range(0, 255));
        endcase
        return pick;
    endfunction

    // Queues one sequence built from alternating pairs (with the odd repeated
    // symbol), homopolymer stretches and random noise, with the end mark on
    // its last symbol. Returns the number of symbols queued.
    function automatic int unsigned queue_sequence();
        int unsigned segments;
        int unsigned len;
        int unsigned reps;
        int unsigned queued;
        logic [7:0]  a;
        logic [7:0]  b;
        queued   = 0;
        segments = $urandom_range(1, 4);
        for (int seg = 0; seg < segments; seg++)
        begin
            a = pick_symbol();
            b = pick_symbol();
            case ($urandom_range(0, 3))
                0, 1:
                begin
                    len = $urandom_range(2, PAIR_SPAN);
                    for (int k = 0; k < len; k++)
                    begin
                        reps = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 4) : 1;
                        repeat (reps)
                        begin
                            push_symbol((k % 2) ? b : a, 1'b0);
                            queued++;
                        end
                    end
                end
                2:
                begin
                    repeat ($urandom_range(1, 6))
                    begin
                        push_symbol(a, 1'b0);
                        queued++;
                    end
                end
                default:
                begin
                    repeat ($urandom_range(1, 4))
                    begin
                        push_symbol(8'($urandom_range(0, 255)), 1'b0);
                        queued++;
                    end
                end
            endcase
        end
        symbol_q[symbol_q.size() - 1].eos = 1'b1;
        return queued;
    endfunction

    // Waits until every queued symbol has been accepted and every awaited
    // result has arrived, then lets the block settle.
    task automatic wait_idle();
        while (symbol_q.size() != 0 || s_tvalid || awaited_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One register write request. The task opens with a clock edge, so that
    // back-to-back writes never lower and raise cfg_valid in the same step.
    task automatic write_reg(input logic idx, input logic [31:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == REG_COMPRESS_ENABLE)
            enable_m = value[0];
        else
            max_len_m = value;
    endtask

    // ------------------------------------------------------------------
    // Time-out: a run that hangs is a failure.
    // ------------------------------------------------------------------
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence: reset, directed cases, then random phases, each phase
    // with its own register setting, the extremes of the limit among them.
    // ------------------------------------------------------------------
    initial
    begin
        logic        phase_enable[PHASE_COUNT];
        logic [31:0] phase_limit[PHASE_COUNT];
        int unsigned phase_items;
        phase_enable = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
        phase_limit  = '{32'd4, 32'd5, 32'hFFFF_FFFF, 32'd7, 32'd0, 32'd6, 32'd1000000000};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Reset values: compression off, so the symbols pass straight through.
        push_symbol(8'h00, 1'b0);
        push_symbol(8'hFF, 1'b1);
        push_symbol(8'hA5, 1'b0);
        wait_idle();

        // A limit of zero behaves as the smallest limit of four.
        write_reg(REG_COMPRESS_ENABLE, 32'd1);
        write_reg(REG_MAX_REPEAT_LEN, 32'd0);

        // A homopolymer, then an over-long 00/FF pair ending in an odd surplus
        // that is released when a new symbol breaks the run.
        push_symbol(8'h00, 1'b0);
        push_symbol(8'h00, 1'b0);
        repeat (4)
        begin
            push_symbol(8'hFF, 1'b0);
            push_symbol(8'h00, 1'b0);
        end
        push_symbol(BASE_A, 1'b0);
        // The end mark falls on a dropped repeat, so only a bare marker comes out.
        push_symbol(BASE_A, 1'b1);
        // A surplus symbol still held when the sequence ends.
        push_symbol(BASE_G, 1'b0);
        push_symbol(BASE_T, 1'b0);
        push_symbol(BASE_G, 1'b0);
        push_symbol(BASE_T, 1'b0);
        push_symbol(BASE_G, 1'b1);
        wait_idle();

        // Switching off in the middle of a sequence clears the run state.
        push_symbol(BASE_A, 1'b0);
        push_symbol(BASE_C, 1'b0);
        wait_idle();
        write_reg(REG_COMPRESS_ENABLE, 32'd0);
        push_symbol(BASE_A, 1'b0);
        wait_idle();
        write_reg(REG_COMPRESS_ENABLE, 32'd1);
        push_symbol(BASE_C, 1'b0);
        push_symbol(BASE_A, 1'b1);
        wait_idle();

        // Random phases of whole sequences.
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            write_reg(REG_COMPRESS_ENABLE, {31'd0, phase_enable[p]});
            write_reg(REG_MAX_REPEAT_LEN, phase_limit[p]);
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
                phase_items += queue_sequence();
            wait_idle();
        end

        if (error_count == 0 && awaited_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
